// ===== rtl/bofc_pkg.sv =====
// shared types, constants and constant-table functions for the band onset flux compressor
package bofc_pkg;

  localparam int NUM_BANDS_DEF = 8;
  localparam int FRAC_BITS_DEF = 12;

  // fixed fraction widths of the q4.12 registers
  localparam int FF_FRAC   = 12;
  localparam int GAIN_FRAC = 12;

  localparam logic [31:0] INV_LOG2_101  = 32'd9843;
  localparam logic [31:0] TENTH_LOG10_2 = 32'd1973;

  localparam logic [63:0] K_0P1 = 64'd6554;
  localparam logic [63:0] K_0P2 = 64'd13107;
  localparam logic [63:0] K_0P3 = 64'd19661;
  localparam logic [63:0] K_0P4 = 64'd26214;
  localparam logic [63:0] K_0P5 = 64'd32768;
  localparam logic [63:0] K_1P2 = 64'd78643;

  localparam logic [20:0] LVL_OFFSET = 21'h10_0000;

  localparam logic [1:0] REG_FRAME_FACTOR = 2'd0;
  localparam logic [1:0] REG_GAINS_LOW    = 2'd1;
  localparam logic [1:0] REG_GAINS_HIGH   = 2'd2;
  localparam logic [1:0] REG_ACTIVE_BANDS = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_Y,
    OP_LOG_INIT,
    OP_LOG_NORM,
    OP_LOG_SQ,
    OP_LEVEL_MUL,
    OP_LEVEL_POST,
    OP_SCR_MUL,
    OP_SCR_POST,
    OP_KNEE_START,
    OP_KNEE_MUL1,
    OP_KNEE_POST1,
    OP_EXP_INIT,
    OP_EXP_STEP,
    OP_EXP_FIN,
    OP_KNEE_MUL2,
    OP_KNEE_POST2,
    OP_GAIN_MUL,
    OP_GAIN_POST,
    OP_FLUX_POST,
    OP_COMMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_Y,
    ST_LOG_INIT,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_LEVEL_MUL,
    ST_LEVEL_POST,
    ST_SCR_MUL,
    ST_SCR_POST,
    ST_KNEE_START,
    ST_KNEE_MUL1,
    ST_KNEE_POST1,
    ST_EXP_INIT,
    ST_EXP_STEP,
    ST_EXP_FIN,
    ST_KNEE_MUL2,
    ST_KNEE_POST2,
    ST_GAIN_MUL,
    ST_GAIN_POST,
    ST_FLUX_POST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] cnt;
    logic       frame_knee;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic above_c1;
    logic above_c2;
    logic knee_hi;
  } status_t;

  typedef logic [15:0][31:0] root_tab_t;

  function automatic logic [63:0] to_q(input logic [63:0] c16, input int frac);
    return ((c16 << frac) + 64'd32768) >> 16;
  endfunction

  function automatic logic [63:0] isqrt_c(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (b > n) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // base-2 log in q16 of a constant
  function automatic logic [63:0] log2q_c(input logic [63:0] y);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] res;
    n = '0;
    for (int j = 0; j < 63; j++) begin
      if ((y >> (j + 1)) != 64'd0) n = 64'(j + 1);
    end
    m = (n > 64'd30) ? (y >> (n - 64'd30)) : (y << (64'd30 - n));
    res = n << 16;
    for (int k = 15; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        res = res | (64'd1 << k);
      end
    end
    if (y == 64'd0) res = '0;
    return res;
  endfunction

  // q30 roots 2^(1/2^(k+1)) by the truncating square root chain
  function automatic root_tab_t make_roots();
    root_tab_t   tab;
    logic [63:0] root;
    root = 64'h8000_0000;
    for (int k = 0; k < 16; k++) begin
      root = isqrt_c(root << 30);
      tab[k] = root[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t EXP_ROOT = make_roots();

endpackage

// ===== rtl/bofc_ctrl.sv =====
// controller state machine sequencing the shared multiplier datapath
module bofc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bofc_pkg::status_t status,
  output bofc_pkg::cmd_t    cmd
);

  bofc_pkg::state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic knee_frame, knee_frame_next;
  logic in_knee, in_knee_next;
  logic out_valid_next;
  bofc_pkg::state_t after_knee;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bofc_pkg::ST_IDLE;
      cnt        <= '0;
      knee_frame <= 1'b0;
      in_knee    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      knee_frame <= knee_frame_next;
      in_knee    <= in_knee_next;
      out_valid  <= out_valid_next;
    end
  end

  assign after_knee = knee_frame ? bofc_pkg::ST_FLUX_POST : bofc_pkg::ST_GAIN_MUL;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    knee_frame_next = knee_frame;
    in_knee_next    = in_knee;
    out_valid_next  = out_valid & ~out_ready;
    in_ready        = 1'b0;
    cmd.op          = bofc_pkg::OP_NONE;
    cmd.cnt         = cnt;
    cmd.frame_knee  = knee_frame;
    unique case (state)
      bofc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op          = bofc_pkg::OP_ACCEPT;
          in_knee_next    = 1'b0;
          knee_frame_next = 1'b0;
          state_next      = bofc_pkg::ST_Y;
        end
      end
      bofc_pkg::ST_Y: begin
        cmd.op     = bofc_pkg::OP_Y;
        state_next = bofc_pkg::ST_LOG_INIT;
      end
      bofc_pkg::ST_LOG_INIT: begin
        cmd.op     = bofc_pkg::OP_LOG_INIT;
        cnt_next   = '0;
        state_next = bofc_pkg::ST_LOG_NORM;
      end
      bofc_pkg::ST_LOG_NORM: begin
        cmd.op = bofc_pkg::OP_LOG_NORM;
        if (cnt == 4'd4) begin
          cnt_next   = '0;
          state_next = bofc_pkg::ST_LOG_SQ;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      bofc_pkg::ST_LOG_SQ: begin
        cmd.op   = bofc_pkg::OP_LOG_SQ;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd15) begin
          state_next = in_knee ? bofc_pkg::ST_KNEE_MUL1 : bofc_pkg::ST_LEVEL_MUL;
        end
      end
      bofc_pkg::ST_LEVEL_MUL: begin
        cmd.op     = bofc_pkg::OP_LEVEL_MUL;
        state_next = bofc_pkg::ST_LEVEL_POST;
      end
      bofc_pkg::ST_LEVEL_POST: begin
        cmd.op     = bofc_pkg::OP_LEVEL_POST;
        state_next = bofc_pkg::ST_SCR_MUL;
      end
      bofc_pkg::ST_SCR_MUL: begin
        cmd.op     = bofc_pkg::OP_SCR_MUL;
        state_next = bofc_pkg::ST_SCR_POST;
      end
      bofc_pkg::ST_SCR_POST: begin
        cmd.op          = bofc_pkg::OP_SCR_POST;
        knee_frame_next = 1'b0;
        in_knee_next    = 1'b1;
        state_next      = bofc_pkg::ST_KNEE_START;
      end
      bofc_pkg::ST_KNEE_START: begin
        cmd.op = bofc_pkg::OP_KNEE_START;
        if (status.above_c1 || status.above_c2) begin
          state_next = bofc_pkg::ST_LOG_INIT;
        end else begin
          state_next = after_knee;
        end
      end
      bofc_pkg::ST_KNEE_MUL1: begin
        cmd.op     = bofc_pkg::OP_KNEE_MUL1;
        state_next = bofc_pkg::ST_KNEE_POST1;
      end
      bofc_pkg::ST_KNEE_POST1: begin
        cmd.op     = bofc_pkg::OP_KNEE_POST1;
        state_next = status.knee_hi ? after_knee : bofc_pkg::ST_EXP_INIT;
      end
      bofc_pkg::ST_EXP_INIT: begin
        cmd.op     = bofc_pkg::OP_EXP_INIT;
        cnt_next   = '0;
        state_next = bofc_pkg::ST_EXP_STEP;
      end
      bofc_pkg::ST_EXP_STEP: begin
        cmd.op   = bofc_pkg::OP_EXP_STEP;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd15) state_next = bofc_pkg::ST_EXP_FIN;
      end
      bofc_pkg::ST_EXP_FIN: begin
        cmd.op     = bofc_pkg::OP_EXP_FIN;
        state_next = bofc_pkg::ST_KNEE_MUL2;
      end
      bofc_pkg::ST_KNEE_MUL2: begin
        cmd.op     = bofc_pkg::OP_KNEE_MUL2;
        state_next = bofc_pkg::ST_KNEE_POST2;
      end
      bofc_pkg::ST_KNEE_POST2: begin
        cmd.op     = bofc_pkg::OP_KNEE_POST2;
        state_next = after_knee;
      end
      bofc_pkg::ST_GAIN_MUL: begin
        cmd.op     = bofc_pkg::OP_GAIN_MUL;
        state_next = bofc_pkg::ST_GAIN_POST;
      end
      bofc_pkg::ST_GAIN_POST: begin
        cmd.op = bofc_pkg::OP_GAIN_POST;
        if (status.last) begin
          knee_frame_next = 1'b1;
          state_next      = bofc_pkg::ST_KNEE_START;
        end else begin
          state_next = bofc_pkg::ST_FINISH;
        end
      end
      bofc_pkg::ST_FLUX_POST: begin
        cmd.op     = bofc_pkg::OP_FLUX_POST;
        state_next = bofc_pkg::ST_FINISH;
      end
      bofc_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.op         = bofc_pkg::OP_COMMIT;
          out_valid_next = 1'b1;
          state_next     = bofc_pkg::ST_IDLE;
        end
      end
      default: state_next = bofc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/bofc_datapath.sv =====
// datapath: config registers, band state, shared multiplier, log and exp iterations
module bofc_datapath #(
  parameter int NUM_BANDS = bofc_pkg::NUM_BANDS_DEF,
  parameter int FRAC_BITS = bofc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic [23:0]       band_power,
  input  logic              last_band,
  input  bofc_pkg::cmd_t    cmd,
  output bofc_pkg::status_t status,
  output logic [2:0]        band_index,
  output logic [15:0]       scaled_band,
  output logic [15:0]       frame_flux,
  output logic              frame_done,
  output logic              count_error
);

  localparam logic [31:0] B_C1    = 32'(bofc_pkg::to_q(bofc_pkg::K_0P1, FRAC_BITS));
  localparam logic [31:0] B_C2    = 32'(bofc_pkg::to_q(bofc_pkg::K_0P5, FRAC_BITS));
  localparam logic [31:0] F_C1    = 32'(bofc_pkg::to_q(bofc_pkg::K_0P2, FRAC_BITS));
  localparam logic [31:0] F_C2    = 32'(bofc_pkg::to_q(bofc_pkg::K_1P2, FRAC_BITS));
  localparam logic [31:0] B_SPAN  = B_C2 - B_C1;
  localparam logic [31:0] F_SPAN  = F_C2 - F_C1;
  localparam logic [20:0] B_LC2   = 21'(bofc_pkg::log2q_c(64'(B_C2)));
  localparam logic [20:0] F_LC2   = 21'(bofc_pkg::log2q_c(64'(F_C2)));
  localparam logic [20:0] B_LSPAN = 21'(bofc_pkg::log2q_c(64'(B_SPAN)));
  localparam logic [20:0] F_LSPAN = 21'(bofc_pkg::log2q_c(64'(F_SPAN)));
  localparam logic [2:0]  LAST_SLOT = 3'(NUM_BANDS - 1);

  // configuration
  logic [15:0] frame_factor;
  logic [63:0] gains_low;
  logic [63:0] gains_high;
  logic [3:0]  active_bands;

  // band state
  logic [15:0] previous_level [NUM_BANDS];
  logic [19:0] flux_sum;
  logic [2:0]  band_position;
  logic        overrun;

  // working registers
  logic [23:0] power;
  logic        last;
  logic [30:0] x;
  logic [30:0] m;
  logic [4:0]  lg_n;
  logic [15:0] lg_frac;
  logic [63:0] prod;
  logic [15:0] diff;
  logic [19:0] sum;
  logic [19:0] v;
  logic        knee_hi;
  logic [19:0] kout;
  logic [20:0] e;
  logic [31:0] r;
  logic [15:0] scaled;
  logic [15:0] flux;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [20:0] lg;
  logic [20:0] lvs;
  logic [31:0] c1, c2, span;
  logic [20:0] lc2, lspan;
  logic [31:0] p16;
  logic [4:0]  norm_s;
  logic        norm_zero;
  logic [31:0] sq;
  logic [15:0] exp_f;
  logic [15:0] exp_g;
  logic [4:0]  exp_i;
  logic [63:0] lvl_full;
  logic [15:0] level;
  logic [15:0] prev;
  logic [63:0] sc_full;
  logic [15:0] scratch;
  logic [20:0] sum_wide;
  logic [63:0] gained;
  logic [63:0] gsel;
  logic [15:0] gain;
  logic        err;
  logic [20:0] hi_d, mid_d;

  assign lg = {lg_n, lg_frac};
  assign lvs = (lg > bofc_pkg::LVL_OFFSET) ? lg - bofc_pkg::LVL_OFFSET : '0;
  assign c1 = cmd.frame_knee ? F_C1 : B_C1;
  assign c2 = cmd.frame_knee ? F_C2 : B_C2;
  assign span = cmd.frame_knee ? F_SPAN : B_SPAN;
  assign lc2 = cmd.frame_knee ? F_LC2 : B_LC2;
  assign lspan = cmd.frame_knee ? F_LSPAN : B_LSPAN;
  assign p16 = cmd.frame_knee ? 32'(bofc_pkg::K_0P3) : 32'(bofc_pkg::K_0P4);
  assign hi_d = (lg > lc2) ? lg - lc2 : '0;
  assign mid_d = (lspan > lg) ? lspan - lg : '0;

  assign norm_s = 5'd16 >> cmd.cnt;
  assign norm_zero = ((m >> (5'd31 - norm_s)) == '0);
  assign exp_f = e[15:0];
  assign exp_g = 16'd0 - exp_f;
  assign exp_i = e[20:16];

  assign prev = previous_level[band_position];
  assign lvl_full = prod >> (32 - FRAC_BITS);
  assign level = (lvl_full > 64'hFFFF) ? 16'hFFFF : lvl_full[15:0];
  assign sc_full = prod >> bofc_pkg::FF_FRAC;
  assign scratch = (sc_full > 64'hFFFF) ? 16'hFFFF : sc_full[15:0];
  assign sum_wide = {1'b0, flux_sum} + 21'(scratch);
  assign gained = prod >> bofc_pkg::GAIN_FRAC;
  assign gsel = band_position[2] ? gains_high : gains_low;
  assign gain = gsel[16 * band_position[1:0] +: 16];

  assign err = overrun || ({1'b0, band_position} >= active_bands) ||
               (last && ({1'b0, band_position} + 4'd1 != active_bands)) ||
               (!last && band_position == LAST_SLOT);

  assign status.last = last;
  assign status.above_c2 = 32'(v) > c2;
  assign status.above_c1 = 32'(v) > c1;
  assign status.knee_hi = knee_hi;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      bofc_pkg::OP_Y: begin
        mul_a = 32'(power);
        mul_b = 32'd100;
      end
      bofc_pkg::OP_LOG_SQ: begin
        mul_a = 32'(m);
        mul_b = 32'(m);
      end
      bofc_pkg::OP_LEVEL_MUL: begin
        mul_a = 32'(lvs);
        mul_b = bofc_pkg::INV_LOG2_101;
      end
      bofc_pkg::OP_SCR_MUL: begin
        mul_a = 32'(diff);
        mul_b = 32'(frame_factor);
      end
      bofc_pkg::OP_KNEE_MUL1: begin
        mul_a = knee_hi ? 32'(hi_d) : 32'(mid_d);
        mul_b = knee_hi ? bofc_pkg::TENTH_LOG10_2 : p16;
      end
      bofc_pkg::OP_EXP_STEP: begin
        mul_a = r;
        mul_b = bofc_pkg::EXP_ROOT[cmd.cnt];
      end
      bofc_pkg::OP_KNEE_MUL2: begin
        mul_a = span;
        mul_b = r;
      end
      bofc_pkg::OP_GAIN_MUL: begin
        mul_a = 32'(kout);
        mul_b = 32'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign sq = mul_p[61:30];

  // configuration and band state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_factor  <= 16'd4096;
      gains_low     <= 64'h1000_1000_1000_1000;
      gains_high    <= 64'h1000_1000_1000_1000;
      active_bands  <= 4'd8;
      flux_sum      <= '0;
      band_position <= '0;
      overrun       <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) previous_level[i] <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          bofc_pkg::REG_FRAME_FACTOR: frame_factor <= cfg_data[15:0];
          bofc_pkg::REG_GAINS_LOW:    gains_low    <= cfg_data;
          bofc_pkg::REG_GAINS_HIGH:   gains_high   <= cfg_data;
          bofc_pkg::REG_ACTIVE_BANDS: active_bands <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.op == bofc_pkg::OP_LEVEL_POST) previous_level[band_position] <= level;
      if (cmd.op == bofc_pkg::OP_COMMIT) begin
        if (last) begin
          flux_sum      <= '0;
          band_position <= '0;
          overrun       <= 1'b0;
        end else begin
          flux_sum <= sum;
          if (band_position != LAST_SLOT) begin
            band_position <= band_position + 3'd1;
          end else begin
            overrun <= 1'b1;
          end
        end
      end
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    case (cmd.op)
      bofc_pkg::OP_ACCEPT: begin
        power <= band_power;
        last  <= last_band;
      end
      bofc_pkg::OP_Y: x <= 31'(32'h0001_0000 + mul_p[31:0]);
      bofc_pkg::OP_LOG_INIT: begin
        lg_frac <= '0;
        if (x == '0) begin
          m    <= 31'h4000_0000;
          lg_n <= '0;
        end else begin
          m    <= x;
          lg_n <= 5'd30;
        end
      end
      bofc_pkg::OP_LOG_NORM: begin
        if (norm_zero) begin
          m    <= m << norm_s;
          lg_n <= lg_n - norm_s;
        end
      end
      bofc_pkg::OP_LOG_SQ: begin
        if (sq[31]) begin
          m <= sq[31:1];
          lg_frac[4'd15 - cmd.cnt] <= 1'b1;
        end else begin
          m <= sq[30:0];
        end
      end
      bofc_pkg::OP_LEVEL_MUL, bofc_pkg::OP_SCR_MUL, bofc_pkg::OP_KNEE_MUL1,
      bofc_pkg::OP_KNEE_MUL2, bofc_pkg::OP_GAIN_MUL: prod <= mul_p;
      bofc_pkg::OP_LEVEL_POST: diff <= (level > prev) ? level - prev : '0;
      bofc_pkg::OP_SCR_POST: begin
        v   <= 20'(scratch);
        sum <= sum_wide[20] ? 20'hF_FFFF : sum_wide[19:0];
      end
      bofc_pkg::OP_KNEE_START: begin
        knee_hi <= status.above_c2;
        x       <= status.above_c2 ? 31'(v) : 31'(32'(v) - c1);
        kout    <= v;
      end
      bofc_pkg::OP_KNEE_POST1: begin
        if (knee_hi) begin
          kout <= 20'(c2 + 32'(prod >> (32 - FRAC_BITS)));
        end else begin
          e <= prod[36:16];
        end
      end
      bofc_pkg::OP_EXP_INIT: r <= 32'h4000_0000;
      bofc_pkg::OP_EXP_STEP: begin
        if (exp_g[4'd15 - cmd.cnt]) r <= sq;
      end
      bofc_pkg::OP_EXP_FIN: begin
        if (exp_i >= 5'd30) begin
          r <= '0;
        end else if (exp_f == '0) begin
          r <= 32'h4000_0000 >> exp_i;
        end else begin
          r <= r >> ({1'b0, exp_i} + 6'd1);
        end
      end
      bofc_pkg::OP_KNEE_POST2: kout <= 20'(c1 + 32'(prod >> 30));
      bofc_pkg::OP_GAIN_POST: begin
        scaled <= (gained > 64'hFFFF) ? 16'hFFFF : gained[15:0];
        v      <= sum;
      end
      bofc_pkg::OP_FLUX_POST: flux <= (kout > 20'hFFFF) ? 16'hFFFF : kout[15:0];
      bofc_pkg::OP_COMMIT: begin
        band_index  <= band_position;
        scaled_band <= scaled;
        frame_flux  <= last ? flux : '0;
        frame_done  <= last;
        count_error <= err;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/band_onset_flux_compressor_unit.sv =====
// top level of the band onset flux compressor
// the 16-step log and exp iterations run on the one shared 32x32 multiplier (two knees max)
// throughput: one request at a time; the next is taken once the result is registered
// reset: synchronous, clears controller, band state and config to defaults at once
module band_onset_flux_compressor_unit #(
  parameter int NUM_BANDS = bofc_pkg::NUM_BANDS_DEF,
  parameter int FRAC_BITS = bofc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] band_power,
  input  logic        last_band,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  band_index,
  output logic [15:0] scaled_band,
  output logic [15:0] frame_flux,
  output logic        frame_done,
  output logic        count_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  bofc_pkg::cmd_t    cmd;
  bofc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  bofc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bofc_datapath #(
    .NUM_BANDS (NUM_BANDS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .band_power  (band_power),
    .last_band   (last_band),
    .cmd         (cmd),
    .status      (status),
    .band_index  (band_index),
    .scaled_band (scaled_band),
    .frame_flux  (frame_flux),
    .frame_done  (frame_done),
    .count_error (count_error)
  );

endmodule

// ===== rtl/bofc_checker.sv =====
// port-level checker for the band onset flux compressor, bound to the top level
module bofc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  band_index,
  input logic [15:0] scaled_band,
  input logic [15:0] frame_flux,
  input logic        frame_done
);

  // flux only shown on the last band of a frame
  a_flux_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> frame_flux == 16'd0)
    else $error("frame_flux nonzero on a non-final band");

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scaled_band) &&
    $stable(frame_flux) && $stable(band_index))
    else $error("stalled result changed");

endmodule

bind band_onset_flux_compressor_unit bofc_checker u_bofc_checker (.*);
